FILE: sv/iee_pkg.sv
// Shared constants, types and key decoding for the infix expression evaluator.
package iee_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int MAX_CHARS   = 16;
	localparam int OUT_W       = 16;
	localparam int CC_W        = $clog2(MAX_CHARS + 1);
	localparam int MD_CNT_W    = $clog2(VALUE_WIDTH);

	localparam logic [7:0] KEY_PLUS  = 8'h2B;
	localparam logic [7:0] KEY_MINUS = 8'h2D;
	localparam logic [7:0] KEY_MUL   = 8'h2A;
	localparam logic [7:0] KEY_DIV   = 8'h2F;
	localparam logic [7:0] KEY_EQ    = 8'h3D;
	localparam logic [7:0] KEY_CLEAR = 8'h23;
	localparam logic [7:0] KEY_ZERO  = 8'h30;
	localparam logic [7:0] RADIX     = 8'd10;

	typedef logic [VALUE_WIDTH-1:0] word_t;

	typedef enum logic [2:0] {
		KC_DIGIT,
		KC_PLUS,
		KC_MINUS,
		KC_MUL,
		KC_DIV,
		KC_EQ,
		KC_CLEAR,
		KC_OTHER
	} key_class_t;

	typedef enum logic [1:0] {
		PD_NONE,
		PD_MUL,
		PD_DIV
	} pend_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT,
		ST_POST
	} ctl_state_t;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_RUN,
		MD_DONE
	} md_state_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

	typedef struct packed {
		logic done;
		logic dz;
	} md_rsp_t;

	function automatic key_class_t classify(input logic [7:0] k);
		key_class_t c;
		if (k >= KEY_ZERO && k < KEY_ZERO + RADIX) c = KC_DIGIT;
		else if (k == KEY_PLUS)  c = KC_PLUS;
		else if (k == KEY_MINUS) c = KC_MINUS;
		else if (k == KEY_MUL)   c = KC_MUL;
		else if (k == KEY_DIV)   c = KC_DIV;
		else if (k == KEY_EQ)    c = KC_EQ;
		else if (k == KEY_CLEAR) c = KC_CLEAR;
		else c = KC_OTHER;
		return c;
	endfunction

	function automatic logic is_op(input key_class_t c);
		return c == KC_PLUS || c == KC_MINUS || c == KC_MUL || c == KC_DIV;
	endfunction

endpackage

FILE: sv/iee_key_if.sv
// Key input channel: valid/ready handshake carrying one ASCII key.
interface iee_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_char;

	modport source (output valid, output key_char, input ready);
	modport sink (input valid, input key_char, output ready);
endinterface

FILE: sv/iee_res_if.sv
// Result channel: valid/ready handshake carrying the evaluated value and error flag.
interface iee_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] value;
	logic               div_zero;

	modport source (output valid, output value, output div_zero, input ready);
	modport sink (input valid, input value, input div_zero, output ready);
endinterface

FILE: sv/infix_expression_evaluator_unit.sv
// Top level of the four-function infix evaluator with precedence.
//
//  channel | dir | payload              | transfer
//  key     | in  | key_char[7:0]        | valid & ready
//  res     | out | value[15:0],div_zero | valid & ready
//
// Digits, ignored keys and '#' are handled in ST_IDLE; an operator or '='
// with no pending * or / passes through ST_POST; with one pending it waits
// in ST_WAIT on the bit-serial multiply/divide unit, one bit a cycle; a
// division by zero skips the unit's run. arst_n resets the control registers
// (op_q to '='), not the unit's datapath. A result waits in an output register;
// keys are still taken then, except a new expression stalls until it leaves.
module infix_expression_evaluator_unit (
	input logic        clk,
	input logic        arst_n,
	iee_key_if.sink    key,
	iee_res_if.source  res
);
	import iee_pkg::*;

	ctl_state_t      state_q, state_d;
	word_t           sum_q, term_q, opnd_q;
	pend_t           pend_q;
	logic            sign_q, fin_q, err_q;
	logic [CC_W-1:0] cnt_q;
	key_class_t      op_q;

	logic               out_valid_q, out_dz_q;
	logic [OUT_W-1:0]   out_value_q;

	key_class_t kc;
	logic       key_xfer, can_count, close;
	word_t      sum_next, opnd_next;
	md_req_t    md_req;
	md_rsp_t    md_rsp;
	word_t      md_res;

	assign kc        = classify(key.key_char);
	assign key.ready = (state_q == ST_IDLE) && !(out_valid_q && !fin_q);
	assign key_xfer  = key.valid && key.ready;
	assign can_count = cnt_q < CC_W'(MAX_CHARS);
	assign close     = key_xfer && !fin_q &&
		(kc == KC_EQ || (is_op(kc) && can_count));
	assign sum_next  = sign_q ? sum_q - term_q : sum_q + term_q;
	assign opnd_next = (opnd_q << 3) + (opnd_q << 1) +
		word_t'(4'(key.key_char - KEY_ZERO));

	assign res.valid    = out_valid_q;
	assign res.value    = out_value_q;
	assign res.div_zero = out_dz_q;

	iee_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (term_q),
		.b      (opnd_q),
		.rsp    (md_rsp),
		.result (md_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		md_req.start  = 1'b0;
		md_req.is_div = (pend_q == PD_DIV);
		case (state_q)
			ST_IDLE: begin
				if (close) begin
					state_d      = (pend_q == PD_NONE) ? ST_POST : ST_WAIT;
					md_req.start = (pend_q != PD_NONE);
				end
			end
			ST_WAIT: begin
				if (md_rsp.done) state_d = ST_POST;
			end
			ST_POST: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			term_q      <= '0;
			opnd_q      <= '0;
			pend_q      <= PD_NONE;
			sign_q      <= 1'b0;
			cnt_q       <= '0;
			fin_q       <= 1'b0;
			err_q       <= 1'b0;
			op_q        <= KC_EQ;
			out_valid_q <= 1'b0;
			out_dz_q    <= 1'b0;
			out_value_q <= '0;
		end else begin
			if (res.valid && res.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (key_xfer && kc == KC_CLEAR) begin
						sum_q  <= '0;
						term_q <= '0;
						opnd_q <= '0;
						pend_q <= PD_NONE;
						sign_q <= 1'b0;
						cnt_q  <= '0;
						fin_q  <= 1'b0;
						err_q  <= 1'b0;
					end else if (key_xfer && !fin_q) begin
						if (kc == KC_EQ) begin
							op_q <= kc;
							if (pend_q == PD_NONE) term_q <= opnd_q;
						end else if (can_count && (kc == KC_DIGIT || is_op(kc))) begin
							cnt_q <= cnt_q + 1'b1;
							if (kc == KC_DIGIT) begin
								opnd_q <= opnd_next;
							end else begin
								op_q <= kc;
								if (pend_q == PD_NONE) term_q <= opnd_q;
							end
						end
					end
				end
				ST_WAIT: begin
					if (md_rsp.done) begin
						term_q <= md_res;
						err_q  <= err_q | md_rsp.dz;
					end
				end
				ST_POST: begin
					opnd_q <= '0;
					case (op_q)
						KC_MUL: pend_q <= PD_MUL;
						KC_DIV: pend_q <= PD_DIV;
						default: begin
							pend_q <= PD_NONE;
							sum_q  <= sum_next;
							term_q <= '0;
							sign_q <= (op_q == KC_MINUS);
						end
					endcase
					if (op_q == KC_EQ) begin
						fin_q       <= 1'b1;
						out_valid_q <= 1'b1;
						out_dz_q    <= err_q;
						out_value_q <= err_q ? '0 : OUT_W'(signed'(sum_next));
					end
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		key.ready |-> state_q == ST_IDLE)
		else $error("key ready while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		md_rsp.done |-> state_q == ST_WAIT)
		else $error("unit finished with no operation waiting");
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.div_zero |-> res.value == '0)
		else $error("nonzero value with division error");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> fin_q)
		else $error("result without end of expression");
endmodule

FILE: sv/iee_mdu.sv
// Bit-serial multiply / divide unit: shift-add product, restoring signed quotient.
module iee_mdu (
	input  logic            clk,
	input  logic            arst_n,
	input  iee_pkg::md_req_t req,
	input  iee_pkg::word_t  a,
	input  iee_pkg::word_t  b,
	output iee_pkg::md_rsp_t rsp,
	output iee_pkg::word_t  result
);
	import iee_pkg::*;

	md_state_t           state_q, state_d;
	word_t               acc_q, a_q, b_q, rem_q;
	logic [MD_CNT_W-1:0] cnt_q;
	logic                neg_q, is_div_q, dz_q;

	logic [VALUE_WIDTH:0] rem_sh;
	logic                 ge;
	logic                 b_zero;
	word_t                a_mag, b_mag;

	assign rem_sh = {rem_q, a_q[VALUE_WIDTH-1]};
	assign ge     = rem_sh >= {1'b0, b_q};
	assign b_zero = (b == '0);
	assign a_mag  = a[VALUE_WIDTH-1] ? word_t'(-a) : a;
	assign b_mag  = b[VALUE_WIDTH-1] ? word_t'(-b) : b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rsp     = '0;
		case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					state_d = (req.is_div && b_zero) ? MD_DONE : MD_RUN;
				end
			end
			MD_RUN: begin
				if (cnt_q == '0) state_d = MD_DONE;
			end
			MD_DONE: begin
				rsp.done = 1'b1;
				rsp.dz   = dz_q;
				state_d  = MD_IDLE;
			end
			default: state_d = MD_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					is_div_q <= req.is_div;
					dz_q     <= req.is_div && b_zero;
					neg_q    <= a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
					cnt_q    <= MD_CNT_W'(VALUE_WIDTH - 1);
					acc_q    <= '0;
					rem_q    <= '0;
					a_q      <= req.is_div ? a_mag : a;
					b_q      <= req.is_div ? b_mag : b;
				end
			end
			MD_RUN: begin
				cnt_q <= cnt_q - 1'b1;
				if (is_div_q) begin
					if (ge) begin
						rem_q <= word_t'(rem_sh - {1'b0, b_q});
						a_q   <= {a_q[VALUE_WIDTH-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[VALUE_WIDTH-1:0];
						a_q   <= {a_q[VALUE_WIDTH-2:0], 1'b0};
					end
				end else begin
					if (b_q[0]) acc_q <= acc_q + a_q;
					a_q <= {a_q[VALUE_WIDTH-2:0], 1'b0};
					b_q <= {1'b0, b_q[VALUE_WIDTH-1:1]};
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		if (!is_div_q) result = acc_q;
		else if (dz_q) result = '0;
		else if (neg_q) result = word_t'(-a_q);
		else result = a_q;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.dz |-> rsp.done && result == '0)
		else $error("divide by zero without zero result");
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(state_q) == MD_RUN || $past(req.start))
		else $error("done without a run");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != MD_IDLE |-> !req.start)
		else $error("start while busy");
endmodule

FILE: sim/infix_expression_evaluator_unit_tb.sv
// Testbench for the infix evaluator: key streams in, predicted results checked in order.
module infix_expression_evaluator_unit_tb;
	import iee_pkg::*;

	localparam int KEY_TARGET  = 1950;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 60;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		word_t value;
		logic  dz;
	} answer_t;

	class calc_tracker;
		word_t       sum;
		word_t       term;
		word_t       operand;
		pend_t       pend;
		logic        minus;
		int unsigned count;
		logic        done;
		logic        err;
		answer_t     pending_answers[$];
		int          errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			sum     = '0;
			term    = '0;
			operand = '0;
			pend    = PD_NONE;
			minus   = 1'b0;
			count   = 0;
			done    = 1'b0;
			err     = 1'b0;
		endfunction

		// signed quotient truncated toward zero, wraps on most negative / -1
		function word_t quotient(word_t a, word_t b);
			int na;
			int nb;
			int q;
			if (b == '0) begin
				err = 1'b1;
				return '0;
			end
			na = $signed(a);
			nb = $signed(b);
			q = (na < 0 ? -na : na) / (nb < 0 ? -nb : nb);
			if ((na < 0) != (nb < 0))
				q = -q;
			return word_t'(q);
		endfunction

		function void close_operand(logic [7:0] op);
			case (pend)
				PD_MUL: term = term * operand;
				PD_DIV: term = quotient(term, operand);
				default: term = operand;
			endcase
			pend = PD_NONE;
			operand = '0;
			if (op == KEY_MUL) begin
				pend = PD_MUL;
			end else if (op == KEY_DIV) begin
				pend = PD_DIV;
			end else begin
				sum = minus ? sum - term : sum + term;
				term = '0;
				minus = (op == KEY_MINUS);
			end
		endfunction

		// returns 1 when the key changes state or yields a result
		function bit take_key(logic [7:0] k);
			bit      digit;
			bit      op;
			answer_t a;
			digit = k >= KEY_ZERO && k < KEY_ZERO + RADIX;
			op = k == KEY_PLUS || k == KEY_MINUS || k == KEY_MUL || k == KEY_DIV;
			if (k == KEY_CLEAR) begin
				clear();
				return 1;
			end
			if (done)
				return 0;
			if (k == KEY_EQ) begin
				close_operand(KEY_EQ);
				done = 1'b1;
				a.value = err ? word_t'(0) : sum;
				a.dz = err;
				pending_answers.push_back(a);
				return 1;
			end
			if (!digit && !op)
				return 0;
			if (count >= MAX_CHARS)
				return 0;
			count++;
			if (digit)
				operand = operand * word_t'(RADIX) + word_t'(k - KEY_ZERO);
			else
				close_operand(k);
			return 1;
		endfunction

		task flag(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(word_t v, logic dz);
			answer_t want;
			if (pending_answers.size() == 0) begin
				flag($sformatf("unexpected result value=%0d div_zero=%0b", $signed(v), dz));
				return;
			end
			want = pending_answers.pop_front();
			if (v !== want.value)
				flag($sformatf("value %0d, want %0d", $signed(v), $signed(want.value)));
			if (dz !== want.dz)
				flag($sformatf("div_zero %0b, want %0b", dz, want.dz));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   quiet = 0;
	int   keys_taken = 0;
	int   answers_seen = 0;
	int   cycle_count = 0;

	calc_tracker book = new();

	iee_key_if key_ch ();
	iee_res_if res_ch ();

	infix_expression_evaluator_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_ch),
		.res    (res_ch)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** infix_expression_evaluator_unit: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			book.check_result(res_ch.value, res_ch.div_zero);
			answers_seen++;
		end
	end

	// result side: short random stalls, plus one long hold-off to back the block up
	initial begin
		int burst;
		int hold;
		bit held;
		burst = 0;
		hold = 0;
		held = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && answers_seen == 6) begin
				held = 1;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				res_ch.ready = 1'b0;
				hold--;
			end else if (burst > 0) begin
				res_ch.ready = 1'b0;
				burst--;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				res_ch.ready = 1'b0;
				burst = $urandom_range(1, 3) - 1;
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	task automatic send_key(input logic [7:0] k);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			key_ch.valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		key_ch.valid = 1'b1;
		key_ch.key_char = k;
		do @(posedge clk); while (!key_ch.ready);
		void'(book.take_key(k));
		keys_taken++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_key(s[i]);
	endtask

	task automatic send_operand(input bit after_div);
		int digits;
		int pick;
		pick = $urandom_range(0, 15);
		if (pick == 0) begin
			digits = 0;
		end else if (after_div && pick < 4) begin
			send_key(KEY_ZERO);
			digits = 0;
		end else if (pick < 6) begin
			digits = 5;
		end else begin
			digits = $urandom_range(1, 2);
		end
		repeat (digits) send_key(KEY_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task automatic send_expression();
		int         terms;
		logic [7:0] op;
		bit         after_div;
		terms = $urandom_range(1, 5);
		after_div = 0;
		for (int t = 0; t < terms; t++) begin
			send_operand(after_div);
			if ($urandom_range(0, 19) == 0)
				send_key(8'($urandom_range(0, 255)));
			if (t == terms - 1)
				break;
			case ($urandom_range(0, 3))
				0: op = KEY_PLUS;
				1: op = KEY_MINUS;
				2: op = KEY_MUL;
				default: op = KEY_DIV;
			endcase
			send_key(op);
			after_div = (op == KEY_DIV);
		end
		if ($urandom_range(0, 9) != 0)
			send_key(KEY_EQ);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) send_key(8'($urandom_range(0, 255)));
		send_key(KEY_CLEAR);
	endtask

	initial begin
		arst_n = 1'b0;
		key_ch.valid = 1'b0;
		key_ch.key_char = 8'h00;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// divide by zero, key after result, clear, most negative / -1,
		// unknown keys, empty operands
		send_text("9/0=");
		send_text("5#");
		send_text("32768/65535=#");
		send_key(8'h00);
		send_key(8'hFF);
		send_text("+2*-=#");

		while (keys_taken < KEY_TARGET) begin
			if (keys_taken > KEY_TARGET - 250)
				quiet = 1;
			if ($urandom_range(0, 11) == 0)
				repeat ($urandom_range(1, 8)) send_key(8'($urandom_range(0, 255)));
			else
				send_expression();
		end
		key_ch.valid = 1'b0;

		while (book.pending_answers.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (book.errors == 0)
			$display("** infix_expression_evaluator_unit: PASSED **");
		else
			$display("** infix_expression_evaluator_unit: FAILED **");
		$finish;
	end

endmodule
